>>> src/tlwm_pkg.sv
// ----------------------------------------------------------------------------
// tlwm_pkg
// Shared types and constants of the text line wrap measurer: commands,
// item kinds passed from the front to the back, configuration bundle.
// ----------------------------------------------------------------------------
package tlwm_pkg;

  // input commands
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_EOS   = 2'd2
  } cmd_e;

  // configuration register indexes
  localparam logic [1:0] CFG_TABLE_LOADED  = 2'd0;
  localparam logic [1:0] CFG_FIXED_ADVANCE = 2'd1;
  localparam logic [1:0] CFG_WRAP_ENABLE   = 2'd2;
  localparam logic [1:0] CFG_WRAP_LIMIT    = 2'd3;

  localparam logic [15:0] FIXED_ADVANCE_RST = 16'd800;

  // special codes
  localparam logic [15:0] ABSENT_MARK     = 16'hFFFF;
  localparam logic [20:0] QMARK_CP        = 21'h3F;
  localparam logic [20:0] NEWLINE_CP      = 21'h0A;
  localparam logic [20:0] FIRST_PRINTABLE = 21'h20;
  localparam logic [15:0] LINES_MAX       = 16'hFFFF;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // classified item kinds
  typedef enum logic [1:0] {
    K_NEWLINE = 2'd0,
    K_CTRL    = 2'd1,
    K_GLYPH   = 2'd2,
    K_EOS     = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] adv;
  } entry_t;

  typedef struct packed {
    logic        table_loaded;
    logic [15:0] fixed_advance;
    logic        wrap_enable;
    logic [31:0] wrap_limit;
  } cfg_t;

endpackage

>>> src/tlwm_front.sv
// ----------------------------------------------------------------------------
// tlwm_front
// Accepts input beats, owns the advance table, runs the clearing pass after
// reset, classifies characters and resolves each glyph advance.
// ----------------------------------------------------------------------------
module tlwm_front #(
  parameter int unsigned TABLE_DEPTH = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlwm_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    in_cmd_i,
  input  logic [20:0]                   in_cp_i,
  input  logic [15:0]                   in_adv_i,
  input  logic [tlwm_pkg::Q_CNT_W-1:0]  q_count_i,
  output logic                          push_o,
  output tlwm_pkg::entry_t              push_entry_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [15:0]      mem_q [TABLE_DEPTH];
  logic [AW-1:0]    clr_q, clr_d;
  logic             clr_busy_q, clr_busy_d;
  logic [15:0]      qmark_q, qmark_d;
  logic             accept;
  logic             in_range;
  logic             is_write;
  logic             is_item;
  tlwm_pkg::kind_e  kind;
  logic             s1_valid_q, s1_valid_d;
  tlwm_pkg::kind_e  s1_kind_q;
  logic             s1_hit_q;
  logic [15:0]      s1_rd_q;
  logic [15:0]      s1_qmark_q;
  logic [15:0]      adv_sel;

  // room check counts the beat already in the read stage
  assign in_ready_o = !clr_busy_q &&
      (({1'b0, q_count_i} + (tlwm_pkg::Q_CNT_W + 1)'(s1_valid_q)) <
       (tlwm_pkg::Q_CNT_W + 1)'(tlwm_pkg::Q_DEPTH));
  assign accept   = in_valid_i && in_ready_o;
  assign in_range = in_cp_i < 21'(TABLE_DEPTH);

  // classify the beat
  always_comb begin
    is_write = 1'b0;
    is_item  = 1'b0;
    kind     = tlwm_pkg::K_GLYPH;
    case (tlwm_pkg::cmd_e'(in_cmd_i))
      tlwm_pkg::CMD_WRITE: begin
        is_write = in_range;
      end
      tlwm_pkg::CMD_CHAR: begin
        is_item = 1'b1;
        if (in_cp_i == tlwm_pkg::NEWLINE_CP) begin
          kind = tlwm_pkg::K_NEWLINE;
        end else if (in_cp_i < tlwm_pkg::FIRST_PRINTABLE) begin
          kind = tlwm_pkg::K_CTRL;
        end
      end
      tlwm_pkg::CMD_EOS: begin
        is_item = 1'b1;
        kind    = tlwm_pkg::K_EOS;
      end
      default: begin
      end
    endcase
  end

  // clearing sweep and fallback glyph copy
  always_comb begin
    clr_d      = clr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      if (clr_q == AW'(TABLE_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_d = clr_q + AW'(1);
      end
    end
    qmark_d = qmark_q;
    if (accept && is_write && in_cp_i == tlwm_pkg::QMARK_CP) begin
      qmark_d = in_adv_i;
    end
    s1_valid_d = accept && is_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
      qmark_q    <= tlwm_pkg::ABSENT_MARK;
      s1_valid_q <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_busy_q <= clr_busy_d;
      qmark_q    <= qmark_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // advance table, one port, registered read
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_q] <= tlwm_pkg::ABSENT_MARK;
    end else if (accept && is_write) begin
      mem_q[in_cp_i[AW-1:0]] <= in_adv_i;
    end
    if (accept && is_item) begin
      s1_rd_q <= mem_q[in_cp_i[AW-1:0]];
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (accept && is_item) begin
      s1_kind_q  <= kind;
      s1_hit_q   <= in_range;
      s1_qmark_q <= qmark_q;
    end
  end

  // glyph advance with fallbacks
  always_comb begin
    if (!cfg_i.table_loaded) begin
      adv_sel = cfg_i.fixed_advance;
    end else if (s1_hit_q && s1_rd_q != tlwm_pkg::ABSENT_MARK) begin
      adv_sel = s1_rd_q;
    end else if (s1_qmark_q != tlwm_pkg::ABSENT_MARK) begin
      adv_sel = s1_qmark_q;
    end else begin
      adv_sel = cfg_i.fixed_advance;
    end
  end

  assign push_o            = s1_valid_q;
  assign push_entry_o.kind = s1_kind_q;
  assign push_entry_o.adv  = adv_sel;

endmodule

>>> src/tlwm_queue.sv
// ----------------------------------------------------------------------------
// tlwm_queue
// Small fifo of classified items between the front and the back.
// ----------------------------------------------------------------------------
module tlwm_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  tlwm_pkg::entry_t              push_entry_i,
  input  logic                          pop_i,
  output tlwm_pkg::entry_t              head_o,
  output logic                          empty_o,
  output logic                          full_o,
  output logic [tlwm_pkg::Q_CNT_W-1:0]  count_o
);

  tlwm_pkg::entry_t                 slot_q [tlwm_pkg::Q_DEPTH];
  logic [tlwm_pkg::Q_PTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [tlwm_pkg::Q_CNT_W-1:0]     cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == tlwm_pkg::Q_CNT_W'(tlwm_pkg::Q_DEPTH);
  assign count_o = cnt_q;
  assign head_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_d  = do_push ? wr_q + tlwm_pkg::Q_PTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + tlwm_pkg::Q_PTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + tlwm_pkg::Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - tlwm_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_entry_i;
    end
  end

endmodule

>>> src/tlwm_back.sv
// ----------------------------------------------------------------------------
// tlwm_back
// Line accumulator: sums advances, applies greedy wrapping, closes lines and
// holds the end of string result in an output register.
// ----------------------------------------------------------------------------
module tlwm_back #(
  parameter int unsigned SUM_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlwm_pkg::cfg_t    cfg_i,
  input  tlwm_pkg::entry_t  head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       out_lines_o,
  output logic [31:0]       out_widest_o
);

  localparam int unsigned CW = (SUM_WIDTH + 1 > 32) ? SUM_WIDTH + 1 : 32;
  localparam int unsigned OW = (SUM_WIDTH > 32) ? SUM_WIDTH : 32;

  logic [SUM_WIDTH-1:0] sum_q, sum_d, widest_q, widest_d;
  logic [15:0]          lines_q, lines_d;
  logic                 has_glyph_q, has_glyph_d;
  logic                 not_empty_q, not_empty_d;
  logic                 out_valid_q, out_valid_d;
  logic [15:0]          out_lines_q, out_lines_d;
  logic [31:0]          out_widest_q, out_widest_d;
  logic [SUM_WIDTH:0]   next_sum;
  logic [SUM_WIDTH-1:0] next_sat;
  logic [SUM_WIDTH-1:0] close_widest;
  logic [15:0]          close_lines;
  logic [OW-1:0]        widest_ext;
  logic                 wrap;

  // only a string end has to wait for the result register
  assign pop_o = !empty_i &&
                 ((head_i.kind != tlwm_pkg::K_EOS) || !out_valid_q || out_ready_i);

  // exact sum, wrap test and values after closing the current line
  assign next_sum     = {1'b0, sum_q} + (SUM_WIDTH + 1)'(head_i.adv);
  assign next_sat     = next_sum[SUM_WIDTH] ? '1 : next_sum[SUM_WIDTH-1:0];
  assign wrap         = cfg_i.wrap_enable && has_glyph_q &&
                        (CW'(next_sum) > CW'(cfg_i.wrap_limit));
  assign close_widest = (sum_q > widest_q) ? sum_q : widest_q;
  assign close_lines  = (lines_q != tlwm_pkg::LINES_MAX) ? lines_q + 16'd1 : lines_q;

  // item processing
  always_comb begin
    sum_d        = sum_q;
    widest_d     = widest_q;
    lines_d      = lines_q;
    has_glyph_d  = has_glyph_q;
    not_empty_d  = not_empty_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_lines_d  = out_lines_q;
    out_widest_d = out_widest_q;
    widest_ext   = OW'(not_empty_q ? close_widest : widest_q);
    if (pop_o) begin
      case (head_i.kind)
        tlwm_pkg::K_NEWLINE: begin
          lines_d     = close_lines;
          widest_d    = close_widest;
          sum_d       = '0;
          has_glyph_d = 1'b0;
          not_empty_d = 1'b0;
        end
        tlwm_pkg::K_CTRL: begin
          not_empty_d = 1'b1;
        end
        tlwm_pkg::K_GLYPH: begin
          has_glyph_d = 1'b1;
          not_empty_d = 1'b1;
          if (wrap) begin
            lines_d  = close_lines;
            widest_d = close_widest;
            sum_d    = SUM_WIDTH'(head_i.adv);
          end else begin
            sum_d = next_sat;
          end
        end
        tlwm_pkg::K_EOS: begin
          out_valid_d  = 1'b1;
          out_lines_d  = not_empty_q ? close_lines : lines_q;
          out_widest_d = (widest_ext > OW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                            : widest_ext[31:0];
          sum_d        = '0;
          widest_d     = '0;
          lines_d      = '0;
          has_glyph_d  = 1'b0;
          not_empty_d  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      widest_q    <= '0;
      lines_q     <= '0;
      has_glyph_q <= 1'b0;
      not_empty_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      widest_q    <= widest_d;
      lines_q     <= lines_d;
      has_glyph_q <= has_glyph_d;
      not_empty_q <= not_empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_lines_q  <= out_lines_d;
    out_widest_q <= out_widest_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_lines_o  = out_lines_q;
  assign out_widest_o = out_widest_q;

endmodule

>>> src/text_line_wrap_measurer.sv
// ----------------------------------------------------------------------------
// text_line_wrap_measurer
// Measures text strings from a codepoint stream: per-glyph advances from a
// writable table, greedy wrapping, line count and widest line per string.
//
//   channel   dir  signals                          contents
//   s_axis    in   tvalid/tready/tdata/tuser        commands and characters
//   m_axis    out  tvalid/tready/tdata              one result per string end
//   cfg       in   cfg_we_i/cfg_idx_i/cfg_wdata_i   register writes
//
// One beat per cycle while the queue has room and the sweep is over; a character
// reaches the accumulator through the table read stage, then the queue head.
// After reset the advance table is swept to absent entry by entry, during which
// s_axis_tready stays low.
// A four-entry queue separates the table read from the line accumulator;
// the result register lets the back keep working until a second result
// meets a stalled m_axis.
// ----------------------------------------------------------------------------
module text_line_wrap_measurer #(
  parameter int unsigned TABLE_DEPTH = 65536,
  parameter int unsigned SUM_WIDTH   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // codepoint[20:0], advance[36:21], zero pad
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // line_count[15:0], widest_sum[47:16]
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  tlwm_pkg::cfg_t                   cfg_q, cfg_d;
  logic                             q_push, q_pop, q_empty, q_full;
  tlwm_pkg::entry_t                 q_in, q_head;
  logic [tlwm_pkg::Q_CNT_W-1:0]     q_count;
  logic [15:0]                      out_lines;
  logic [31:0]                      out_widest;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tlwm_pkg::CFG_TABLE_LOADED:  cfg_d.table_loaded  = cfg_wdata_i[0];
        tlwm_pkg::CFG_FIXED_ADVANCE: cfg_d.fixed_advance = cfg_wdata_i[15:0];
        tlwm_pkg::CFG_WRAP_ENABLE:   cfg_d.wrap_enable   = cfg_wdata_i[0];
        tlwm_pkg::CFG_WRAP_LIMIT:    cfg_d.wrap_limit    = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_loaded  <= 1'b0;
      cfg_q.fixed_advance <= tlwm_pkg::FIXED_ADVANCE_RST;
      cfg_q.wrap_enable   <= 1'b0;
      cfg_q.wrap_limit    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: accept, table, classify
  tlwm_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_cp_i      (s_axis_tdata[20:0]),
    .in_adv_i     (s_axis_tdata[36:21]),
    .q_count_i    (q_count),
    .push_o       (q_push),
    .push_entry_o (q_in)
  );

  // item queue
  tlwm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .empty_o      (q_empty),
    .full_o       (q_full),
    .count_o      (q_count)
  );

  // back: line accumulation and result
  tlwm_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (q_head),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_lines_o  (out_lines),
    .out_widest_o (out_widest)
  );

  assign m_axis_tdata = {out_widest, out_lines};

  // queue never overflows under the front's room check
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("item pushed into a full queue");

  // back only pops a present item
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("pop from an empty queue");

  // a nonzero widest line implies at least one closed line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && out_widest != 32'd0) |-> out_lines != 16'd0)
    else $error("widest sum without any line");

endmodule

>>> sim/tb_text_line_wrap_measurer.sv
// ----------------------------------------------------------------------------
// tb_text_line_wrap_measurer
// Self-checking bench for the text line wrap measurer. A directed table walks
// reset defaults, control characters, newlines, the missing-glyph fallbacks,
// ignored commands and wrap limits. Then one string of the widest advances
// builds a large line sum. Random phases with random register settings
// follow. Every string-end beat is predicted by its table row or by an in-bench
// measure model and checked field by field against the result stream.
// ----------------------------------------------------------------------------
module tb_text_line_wrap_measurer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 65536;
  localparam int unsigned SUM_WIDTH   = 32;
  localparam longint unsigned SUM_MAX = 64'hFFFF_FFFF;
  localparam logic [1:0]  CMD_NONE    = 2'd3;   // unused command code
  localparam int unsigned SETTLE      = 20;     // cycles for in-flight beats
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned RAND_ITEMS  = 1080;
  localparam int unsigned STRESS_GLYPHS = 24;

  typedef struct packed {
    logic [31:0] widest;
    logic [15:0] lines;
  } measure_t;

  typedef struct {
    bit          is_reg;
    logic [1:0]  code;      // command, or register index for register rows
    logic [20:0] cp;
    logic [31:0] val;       // advance, or register value
    bit          typed;
    measure_t    want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // codepoint[20:0], advance[36:21], zero pad
  logic [1:0]  s_axis_tuser;   // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // line_count[15:0], widest_sum[47:16]
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  // measure model state
  logic [15:0]     glyph_adv [TABLE_DEPTH];
  longint unsigned line_acc;
  longint unsigned widest_acc;
  logic [15:0]     lines_acc;
  bit              line_glyph;
  bit              line_marked;
  bit              cfg_tbl_on;
  logic [15:0]     cfg_fixed;
  bit              cfg_wrap_on;
  longint unsigned cfg_limit;

  measure_t    pending_measures [$];
  stim_row_t   stim_rows [$];
  int unsigned mismatches;
  bit          src_idle_on;
  bit          sink_idle_on;
  bit          long_hold_req;

  text_line_wrap_measurer #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // run limit
  initial begin
    #15_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // measure model
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] glyph_width(logic [20:0] cp);
    if (!cfg_tbl_on) return cfg_fixed;
    if (cp < TABLE_DEPTH && glyph_adv[cp[15:0]] != tlwm_pkg::ABSENT_MARK)
      return glyph_adv[cp[15:0]];
    if (glyph_adv[16'(tlwm_pkg::QMARK_CP)] != tlwm_pkg::ABSENT_MARK)
      return glyph_adv[16'(tlwm_pkg::QMARK_CP)];
    return cfg_fixed;
  endfunction

  function automatic void close_line();
    if (lines_acc != tlwm_pkg::LINES_MAX) lines_acc++;
    if (line_acc > widest_acc) widest_acc = line_acc;
    line_acc    = 0;
    line_glyph  = 1'b0;
    line_marked = 1'b0;
  endfunction

  // advances the model by one accepted beat, returns 1 when a result is due
  function automatic bit measure_beat(input logic [1:0] cmd, input logic [20:0] cp,
                                      input logic [15:0] adv, output measure_t res);
    longint unsigned w;
    longint unsigned nxt;
    res = '0;
    case (cmd)
      tlwm_pkg::CMD_WRITE: begin
        if (cp < TABLE_DEPTH) glyph_adv[cp[15:0]] = adv;
      end
      tlwm_pkg::CMD_CHAR: begin
        if (cp == tlwm_pkg::NEWLINE_CP) begin
          close_line();
        end else if (cp < tlwm_pkg::FIRST_PRINTABLE) begin
          line_marked = 1'b1;
        end else begin
          w   = 64'(glyph_width(cp));
          nxt = line_acc + w;
          // greedy wrap: close the line before the glyph that overflows it
          if (cfg_wrap_on && line_glyph && nxt > cfg_limit) begin
            close_line();
            nxt = w;
          end
          line_acc    = (nxt > SUM_MAX) ? SUM_MAX : nxt;
          line_glyph  = 1'b1;
          line_marked = 1'b1;
        end
      end
      tlwm_pkg::CMD_EOS: begin
        if (line_marked) close_line();
        res.lines  = lines_acc;
        res.widest = widest_acc[31:0];
        line_acc    = 0;
        widest_acc  = 0;
        lines_acc   = '0;
        line_glyph  = 1'b0;
        line_marked = 1'b0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin : result_check
    measure_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_measures.size() == 0) begin
        note_mismatch("unexpected result, line_count", '0, 32'(m_axis_tdata[15:0]));
      end else begin
        want = pending_measures.pop_front();
        if (m_axis_tdata[15:0] !== want.lines)
          note_mismatch("line_count", 32'(want.lines), 32'(m_axis_tdata[15:0]));
        if (m_axis_tdata[47:16] !== want.widest)
          note_mismatch("widest_sum", want.widest, m_axis_tdata[47:16]);
      end
    end
  end

  // result side: random stalls, one long hold on request
  initial begin : result_sink
    int unsigned n;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // beat driving
  // ---------------------------------------------------------------------------

  // offer one beat, wait for the handshake, then record its expectation
  task automatic send_beat(logic [1:0] cmd, logic [20:0] cp, logic [15:0] adv,
                           bit typed = 1'b0, measure_t want = '0);
    measure_t res;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, adv, cp};
    do @(posedge clk_i); while (!s_axis_tready);
    if (measure_beat(cmd, cp, adv, res))
      pending_measures.insert(pending_measures.size(), typed ? want : res);
  endtask

  task automatic maybe_gap();
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // stop offering and let every result come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_measures.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      tlwm_pkg::CFG_TABLE_LOADED:  cfg_tbl_on  = val[0];
      tlwm_pkg::CFG_FIXED_ADVANCE: cfg_fixed   = val[15:0];
      tlwm_pkg::CFG_WRAP_ENABLE:   cfg_wrap_on = val[0];
      tlwm_pkg::CFG_WRAP_LIMIT:    cfg_limit   = 64'(val);
      default: ;
    endcase
  endtask

  task automatic program_regs(bit tbl_on, logic [15:0] fixed_adv, bit wrap_on,
                              logic [31:0] limit);
    drain();
    write_reg(tlwm_pkg::CFG_TABLE_LOADED, {31'd0, tbl_on});
    write_reg(tlwm_pkg::CFG_FIXED_ADVANCE, {16'd0, fixed_adv});
    write_reg(tlwm_pkg::CFG_WRAP_ENABLE, {31'd0, wrap_on});
    write_reg(tlwm_pkg::CFG_WRAP_LIMIT, limit);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // directed table rows
  // ---------------------------------------------------------------------------

  task automatic row_beat(logic [1:0] cmd, logic [20:0] cp, logic [15:0] adv);
    stim_rows.insert(stim_rows.size(), '{1'b0, cmd, cp, {16'd0, adv}, 1'b0, '0});
  endtask

  task automatic row_eos(logic [15:0] lines, logic [31:0] widest);
    measure_t want;
    want.lines  = lines;
    want.widest = widest;
    stim_rows.insert(stim_rows.size(),
                     '{1'b0, tlwm_pkg::CMD_EOS, 21'd0, 32'd0, 1'b1, want});
  endtask

  task automatic row_reg(logic [1:0] idx, logic [31:0] val);
    stim_rows.insert(stim_rows.size(), '{1'b1, idx, 21'd0, val, 1'b0, '0});
  endtask

  // ---------------------------------------------------------------------------
  // random picks
  // ---------------------------------------------------------------------------

  function automatic logic [20:0] pick_cp();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 21'($urandom_range(32'h20, 32'h5F));
    if (r < 72) return tlwm_pkg::QMARK_CP;
    if (r < 80) return 21'h00FFFF;
    if (r < 90) return 21'($urandom_range(0, 32'hFFFF));
    return 21'($urandom_range(32'h1_0000, 32'h10_FFFF));
  endfunction

  function automatic logic [15:0] pick_adv();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(0, 1500));
    if (r < 72) return tlwm_pkg::ABSENT_MARK;
    if (r < 77) return 16'hFFFE;
    if (r < 82) return 16'd0;
    return 16'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    int unsigned r;
    int unsigned eos_pct;
    bit          quiet;
    logic [20:0] cp;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    mismatches    = 0;
    long_hold_req = 1'b0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;

    // model reset
    foreach (glyph_adv[i]) glyph_adv[i] = tlwm_pkg::ABSENT_MARK;
    line_acc    = 0;
    widest_acc  = 0;
    lines_acc   = '0;
    line_glyph  = 1'b0;
    line_marked = 1'b0;
    cfg_tbl_on  = 1'b0;
    cfg_fixed   = tlwm_pkg::FIXED_ADVANCE_RST;
    cfg_wrap_on = 1'b0;
    cfg_limit   = 0;

    // reset defaults: fixed advances, no wrapping
    row_eos(16'd0, 32'd0);                       // empty string
    row_beat(tlwm_pkg::CMD_CHAR, 21'h41, 16'd0);
    row_beat(tlwm_pkg::CMD_CHAR, 21'h10_FFFF, 16'd0);      // beyond the table
    row_eos(16'd1, 32'd1600);
    row_beat(tlwm_pkg::CMD_CHAR, 21'h00, 16'd0);           // control only line counts
    row_eos(16'd1, 32'd0);
    row_beat(tlwm_pkg::CMD_CHAR, tlwm_pkg::NEWLINE_CP, 16'd0);
    row_beat(tlwm_pkg::CMD_CHAR, tlwm_pkg::NEWLINE_CP, 16'd0);
    row_eos(16'd2, 32'd0);
    row_beat(tlwm_pkg::CMD_WRITE, tlwm_pkg::QMARK_CP, 16'd500);
    row_beat(tlwm_pkg::CMD_WRITE, 21'h10_FFFF, 16'd7);     // out of range write dropped
    row_beat(CMD_NONE, 21'h41, 16'hFFFF);                  // unknown command dropped
    row_beat(tlwm_pkg::CMD_CHAR, 21'h1F, 16'd0);
    row_beat(tlwm_pkg::CMD_CHAR, 21'h7E, 16'd0);
    row_eos(16'd1, 32'd800);
    // table on, zero limit gives one glyph per line
    row_reg(tlwm_pkg::CFG_TABLE_LOADED, 32'd1);
    row_reg(tlwm_pkg::CFG_WRAP_ENABLE, 32'd1);
    row_reg(tlwm_pkg::CFG_WRAP_LIMIT, 32'd0);
    row_beat(tlwm_pkg::CMD_WRITE, 21'h41, 16'd100);
    row_beat(tlwm_pkg::CMD_WRITE, 21'h00_FFFF, 16'd0);     // top entry, zero width
    row_beat(tlwm_pkg::CMD_CHAR, 21'h41, 16'd0);
    row_beat(tlwm_pkg::CMD_CHAR, 21'h41, 16'd0);
    row_beat(tlwm_pkg::CMD_CHAR, 21'h00_FFFF, 16'd0);
    row_eos(16'd3, 32'd100);
    // missing glyph takes '?', then fixed once '?' is gone too
    row_beat(tlwm_pkg::CMD_CHAR, 21'h42, 16'd0);
    row_beat(tlwm_pkg::CMD_WRITE, tlwm_pkg::QMARK_CP, tlwm_pkg::ABSENT_MARK);
    row_beat(tlwm_pkg::CMD_CHAR, 21'h43, 16'd0);
    row_eos(16'd2, 32'd800);
    // largest fixed advance, widest limit
    row_reg(tlwm_pkg::CFG_FIXED_ADVANCE, 32'd65534);
    row_reg(tlwm_pkg::CFG_WRAP_LIMIT, 32'hFFFF_FFFF);
    row_beat(tlwm_pkg::CMD_CHAR, 21'h43, 16'd0);
    row_beat(tlwm_pkg::CMD_CHAR, tlwm_pkg::NEWLINE_CP, 16'd0);
    row_beat(tlwm_pkg::CMD_CHAR, tlwm_pkg::FIRST_PRINTABLE, 16'd0);
    row_eos(16'd2, 32'd65534);
    // a sum equal to the limit stays on the line
    row_reg(tlwm_pkg::CFG_WRAP_LIMIT, 32'd200);
    row_beat(tlwm_pkg::CMD_CHAR, 21'h41, 16'd0);
    row_beat(tlwm_pkg::CMD_CHAR, 21'h41, 16'd0);
    row_eos(16'd1, 32'd200);

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // directed part
    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_reg) begin
        drain();
        write_reg(stim_rows[i].code, stim_rows[i].val);
        cfg_we_i <= 1'b0;
      end else begin
        send_beat(stim_rows[i].code, stim_rows[i].cp, stim_rows[i].val[15:0],
                  stim_rows[i].typed, stim_rows[i].want);
        maybe_gap();
      end
    end

    // one string of the widest advances builds a large line sum
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    program_regs(1'b0, 16'd65534, 1'b0, 32'd0);
    repeat (STRESS_GLYPHS) send_beat(tlwm_pkg::CMD_CHAR, 21'h41, 16'd0);
    send_beat(tlwm_pkg::CMD_EOS, 21'd0, 16'd0);

    // random phases, each under its own register setting
    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      case (phase)
        0: program_regs(1'b0, 16'd0, 1'b1, 32'd0);
        1: program_regs(1'b1, 16'd65534, 1'b1, 32'hFFFF_FFFF);
        2: program_regs(1'b1, 16'd0, 1'b1, 32'd1);
        3: program_regs(1'b0, 16'd65534, 1'b0, 32'd0);
        default: begin
          r = $urandom_range(0, 9);
          program_regs(1'($urandom_range(0, 1)),
                       (r < 6) ? 16'($urandom_range(0, 3000)) : 16'($urandom_range(0, 65534)),
                       ($urandom_range(0, 3) != 0),
                       (r < 7) ? 32'($urandom_range(0, 8000)) : 32'($urandom()));
        end
      endcase
      quiet        = (sent + 150 > RAND_ITEMS);
      src_idle_on  = !quiet && ($urandom_range(0, 3) != 0);
      sink_idle_on = !quiet && ($urandom_range(0, 3) != 0);
      eos_pct      = 8;
      // long result stall while string ends keep coming
      if (phase == 5) begin
        long_hold_req = 1'b1;
        src_idle_on   = 1'b0;
        eos_pct       = 45;
      end
      n = $urandom_range(30, 110);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          send_beat(CMD_NONE, 21'($urandom_range(0, 32'h10_FFFF)), 16'($urandom()));
        end else begin
          if (r < 2 + eos_pct) begin
            send_beat(tlwm_pkg::CMD_EOS, 21'($urandom_range(0, 32'h10_FFFF)),
                      16'($urandom()));
          end else if (r < 20 + eos_pct) begin
            send_beat(tlwm_pkg::CMD_WRITE, pick_cp(), pick_adv());
          end else begin
            r = $urandom_range(0, 99);
            if (r < 12) cp = tlwm_pkg::NEWLINE_CP;
            else if (r < 18) cp = 21'($urandom_range(0, 32'h1F));
            else cp = pick_cp();
            send_beat(tlwm_pkg::CMD_CHAR, cp, 16'($urandom()));
          end
          sent++;
        end
        maybe_gap();
      end
      send_beat(tlwm_pkg::CMD_EOS, 21'd0, 16'd0);
      sent++;
      phase++;
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && pending_measures.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/tlwm_pkg.sv
src/tlwm_front.sv
src/tlwm_queue.sv
src/tlwm_back.sv
src/text_line_wrap_measurer.sv
sim/tb_text_line_wrap_measurer.sv
